/* hw/rtl/iecs_pkg.sv */
// Shared types and constants for the ICMP echo reply checksum block.
// No dependencies; the top level, the byte parser and the checksum finisher import this package.
`default_nettype none

package iecs_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LEN_W         = 16;
  localparam int END_W         = LEN_W + 1;
  localparam int SUM_W         = 32;

  localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;
  localparam logic [POSITION_BITS-1:0] ICMP_OFFSET  = POSITION_BITS'(34);
  localparam logic [POSITION_BITS-1:0] ETH_TYPE_HI  = POSITION_BITS'(12);
  localparam logic [POSITION_BITS-1:0] ETH_TYPE_LO  = POSITION_BITS'(13);
  localparam logic [POSITION_BITS-1:0] IP_VER_IHL   = POSITION_BITS'(14);
  localparam logic [POSITION_BITS-1:0] IP_LEN_HI    = POSITION_BITS'(16);
  localparam logic [POSITION_BITS-1:0] IP_LEN_LO    = POSITION_BITS'(17);
  localparam logic [POSITION_BITS-1:0] ICMP_CSUM_HI = ICMP_OFFSET + POSITION_BITS'(2);
  localparam logic [POSITION_BITS-1:0] ICMP_CSUM_LO = ICMP_OFFSET + POSITION_BITS'(3);

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  TYPE_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  TYPE_ECHO_REPLY   = 8'd0;
  localparam logic [15:0] CSUM_MASK         = 16'hffff;

  // Per-frame state handed from the byte parser to the checksum finisher.
  typedef struct packed {
    logic                     match;
    logic [SUM_W-1:0]         sum;
    logic [7:0]               hold;
    logic                     pending;
    logic [POSITION_BITS-1:0] pos;
    logic [LEN_W-1:0]         total_length;
    logic [3:0]               header_words;
  } summary_t;

endpackage

`default_nettype wire

/* hw/rtl/iecs_byte_if.sv */
// Valid/ready channel interfaces for frame bytes in and checksum results out.
// Depends on nothing beyond the fixed field widths.
`default_nettype none

interface iecs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface iecs_result_if;
  logic        valid;
  logic        ready;
  logic        is_echo_request;
  logic [15:0] reply_checksum;
  logic        truncated;

  modport source(output valid, is_echo_request, reply_checksum, truncated, input ready);
  modport sink(input valid, is_echo_request, reply_checksum, truncated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/icmp_echo_reply_checksum.sv */
// A frame's result passes through the input register, the pad stage and the output register.
// Throughput: one byte per cycle, except while a last byte waits; the running sum takes one add per byte pair.
// A result waiting at the output does not stall bytes; a last byte waits only while
// both the pad stage and the output register hold results the sink has not taken.
// Reset (rst, synchronous, active high) drops all queued requests and clears frame state.
// Top level; depends on iecs_pkg, iecs_byte_if.sv, iecs_parse and iecs_fold.
`default_nettype none

module icmp_echo_reply_checksum (
  input  wire logic     clk,
  input  wire logic     rst,
  iecs_byte_if.sink     frame,
  iecs_result_if.source result
);
  import iecs_pkg::*;

  // Frame summary captured on the last byte of each request stream.
  summary_t summary;
  logic     summary_valid;
  logic     summary_ready;

  // Stage 1: input register, header fields, word sum over the ICMP bytes.
  iecs_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .frame         (frame),
    .summary       (summary),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready)
  );

  // Stages 2 and 3: odd-byte pad and length check, then fold into the result register.
  iecs_fold u_fold (
    .clk           (clk),
    .rst           (rst),
    .summary       (summary),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready),
    .result        (result)
  );

endmodule

`default_nettype wire

/* hw/rtl/iecs_parse.sv */
// Byte parser: input register, header capture and running ICMP word sum.
// Depends on iecs_pkg and iecs_byte_if.
`default_nettype none

module iecs_parse (
  input  wire logic       clk,
  input  wire logic       rst,
  iecs_byte_if.sink       frame,
  output iecs_pkg::summary_t summary,
  output logic            summary_valid,
  input  wire logic       summary_ready
);
  import iecs_pkg::*;

  logic                     in_v;
  logic [7:0]               in_byte;
  logic                     in_last;
  logic                     take;
  logic                     step;

  logic [POSITION_BITS-1:0] pos,        pos_next;
  logic [15:0]              ether_type, ether_type_next;
  logic [3:0]               hdr_words,  hdr_words_next;
  logic [LEN_W-1:0]         tot_len,    tot_len_next;
  logic [7:0]               msg_type,   msg_type_next;
  logic [SUM_W-1:0]         run_sum,    run_sum_next;
  logic [7:0]               hold,       hold_next;
  logic                     pending,    pending_next;

  // Derived from the captured header and registered; only read at ICMP bytes.
  logic                     under;
  logic [END_W-1:0]         icmp_end;
  logic [LEN_W-1:0]         hdr_bytes;
  logic                     under_next;
  logic [END_W-1:0]         icmp_end_next;
  logic                     in_icmp;
  logic [7:0]               word_byte;

  assign take          = !in_last || summary_ready;
  assign step          = in_v && take;
  assign frame.ready   = !in_v || take;
  assign summary_valid = in_v && in_last;

  assign hdr_bytes     = {{(LEN_W-6){1'b0}}, hdr_words, 2'b00};
  assign under_next    = tot_len < hdr_bytes;
  assign icmp_end_next = END_W'(ICMP_OFFSET) + (under_next ? END_W'(0)
                                               : END_W'(tot_len - hdr_bytes));

  assign in_icmp = (pos >= ICMP_OFFSET) && !under && (END_W'(pos) < icmp_end);

  always_comb begin
    pos_next        = pos;
    ether_type_next = ether_type;
    hdr_words_next  = hdr_words;
    tot_len_next    = tot_len;
    msg_type_next   = msg_type;
    run_sum_next    = run_sum;
    hold_next       = hold;
    pending_next    = pending;
    word_byte       = in_byte;
    if (step && pos != POSITION_MAX) begin
      if (pos == ETH_TYPE_HI) ether_type_next[15:8] = in_byte;
      else if (pos == ETH_TYPE_LO) ether_type_next[7:0] = in_byte;
      else if (pos == IP_VER_IHL) hdr_words_next = in_byte[3:0];
      else if (pos == IP_LEN_HI) tot_len_next[15:8] = in_byte;
      else if (pos == IP_LEN_LO) tot_len_next[7:0] = in_byte;

      if (pos == ICMP_OFFSET) msg_type_next = in_byte;

      // Type goes out as echo reply; the checksum field sums as zero.
      if (pos == ICMP_OFFSET) word_byte = TYPE_ECHO_REPLY;
      else if (pos == ICMP_CSUM_HI || pos == ICMP_CSUM_LO) word_byte = 8'h00;

      if (in_icmp) begin
        if (pos[0] == ICMP_OFFSET[0]) begin
          hold_next    = word_byte;
          pending_next = 1'b1;
        end else begin
          run_sum_next = run_sum + {{(SUM_W-16){1'b0}}, hold, word_byte};
          pending_next = 1'b0;
        end
      end
      pos_next = pos + POSITION_BITS'(1);
    end
  end

  always_comb begin
    summary.match        = (ether_type_next == ETHERTYPE_IPV4) &&
                           (msg_type_next == TYPE_ECHO_REQUEST);
    summary.sum          = run_sum_next;
    summary.hold         = hold_next;
    summary.pending      = pending_next;
    summary.pos          = pos_next;
    summary.total_length = tot_len_next;
    summary.header_words = hdr_words_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v       <= 1'b0;
      in_byte    <= '0;
      in_last    <= 1'b0;
      pos        <= '0;
      ether_type <= '0;
      hdr_words  <= '0;
      tot_len    <= '0;
      msg_type   <= '0;
      run_sum    <= '0;
      hold       <= '0;
      pending    <= 1'b0;
      under      <= 1'b0;
      icmp_end   <= '0;
    end else begin
      if (frame.ready) begin
        in_v    <= frame.valid;
        in_byte <= frame.data_byte;
        in_last <= frame.last_byte;
      end
      under    <= under_next;
      icmp_end <= icmp_end_next;
      if (step && in_last) begin
        pos        <= '0;
        ether_type <= '0;
        hdr_words  <= '0;
        tot_len    <= '0;
        msg_type   <= '0;
        run_sum    <= '0;
        hold       <= '0;
        pending    <= 1'b0;
      end else begin
        pos        <= pos_next;
        ether_type <= ether_type_next;
        hdr_words  <= hdr_words_next;
        tot_len    <= tot_len_next;
        msg_type   <= msg_type_next;
        run_sum    <= run_sum_next;
        hold       <= hold_next;
        pending    <= pending_next;
      end
    end
  end

`ifndef SYNTHESIS
  // Frame state is cleared after the final byte goes through.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> pos == '0 && run_sum == '0 && !pending)
    else $error("frame state not cleared after last byte");

  // A half word can only be pending once the ICMP bytes have begun.
  a_pending_in_icmp: assert property (@(posedge clk) disable iff (rst)
    pending |-> pos > ICMP_OFFSET)
    else $error("half word pending before ICMP offset");
`endif

endmodule

`default_nettype wire

/* hw/rtl/iecs_fold.sv */
// Checksum finisher: pad add and length check, then fold, invert and output register.
// Depends on iecs_pkg and iecs_result_if.
`default_nettype none

module iecs_fold (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire iecs_pkg::summary_t summary,
  input  wire logic          summary_valid,
  output logic               summary_ready,
  iecs_result_if.source      result
);
  import iecs_pkg::*;

  logic                     p_v;
  logic [SUM_W-1:0]         p_sum;
  logic                     p_match;
  logic                     p_trunc;
  logic                     p_go;

  logic                     o_v;
  logic                     o_match;
  logic [15:0]              o_csum;
  logic                     o_trunc;

  logic [SUM_W-1:0]         pad;
  logic [LEN_W-1:0]         hdr_bytes;
  logic                     under;
  logic [LEN_W-1:0]         icmp_bytes;
  logic [POSITION_BITS-1:0] got;
  logic                     trunc;
  logic [16:0]              fold1;
  logic [16:0]              fold2;
  logic [15:0]              csum;

  assign p_go          = !o_v || result.ready;
  assign summary_ready = !p_v || p_go;

  // Odd ICMP length: last byte still held, added as a high byte.
  assign pad        = summary.pending ? {{(SUM_W-16){1'b0}}, summary.hold, 8'h00} : '0;
  assign hdr_bytes  = {{(LEN_W-6){1'b0}}, summary.header_words, 2'b00};
  assign under      = summary.total_length < hdr_bytes;
  assign icmp_bytes = under ? '0 : summary.total_length - hdr_bytes;
  assign got        = (summary.pos > ICMP_OFFSET) ? summary.pos - ICMP_OFFSET : '0;
  assign trunc      = under || (LEN_W'(got) < icmp_bytes);

  // End-around carry, twice, then ones-complement.
  assign fold1 = {1'b0, p_sum[15:0]} + {1'b0, p_sum[31:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'h0000, fold1[16]};
  assign csum  = ~fold2[15:0] & CSUM_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (summary_ready) begin
        p_v <= summary_valid;
      end
      if (p_go) begin
        o_v <= p_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (summary_ready && summary_valid) begin
      p_sum   <= summary.sum + pad;
      p_match <= summary.match;
      p_trunc <= trunc;
    end
    if (p_go && p_v) begin
      o_match <= p_match;
      o_csum  <= p_match ? csum : 16'h0000;
      o_trunc <= p_trunc;
    end
  end

  assign result.valid           = o_v;
  assign result.is_echo_request = o_match;
  assign result.reply_checksum  = o_csum;
  assign result.truncated       = o_trunc;

`ifndef SYNTHESIS
  // A result only appears after a finished frame sat in the pad stage.
  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(o_v) |-> $past(p_v))
    else $error("result valid without a frame in the pad stage");

  // Non-matching frames always report a zero checksum.
  a_zero_when_unmatched: assert property (@(posedge clk) disable iff (rst)
    o_v && !o_match |-> o_csum == 16'h0000)
    else $error("checksum nonzero on unmatched frame");
`endif

endmodule

`default_nettype wire
